// File: design/bvm_pkg.sv
// bvm_pkg: shared types and constants of the balance and velocity motor loop
// holds the configuration register set, register index codes and reset values
// no dependencies
`default_nettype none

package bvm_pkg;

    localparam int TERM_W   = 24;
    localparam int DUTY_W   = 16;
    localparam int GAIN_W   = 24;
    localparam int ANGLE_W  = 17;
    localparam int RATE_W   = 16;
    localparam int COUNT_W  = 16;
    localparam int TARGET_W = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // speed integral limits and its register width
    localparam int SPEED_INT_W = 15;
    localparam int SPEED_INT_LIM = 10000;

    // reciprocal of 20 in 0.16 form, exact for target magnitudes up to 1024
    localparam int RECIP20 = 3277;
    localparam int RECIP20_SHIFT = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_GAIN     = 3'd0,
        REG_SPEED_INT_GAIN = 3'd1,
        REG_TILT_GAIN      = 3'd2,
        REG_TILT_RATE_GAIN = 3'd3,
        REG_TILT_INT_GAIN  = 3'd4,
        REG_BALANCE_OFFSET = 3'd5,
        REG_DUTY_CAP       = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0]  speed_gain;
        logic signed [GAIN_W-1:0]  speed_int_gain_base;
        logic signed [GAIN_W-1:0]  tilt_gain;
        logic signed [GAIN_W-1:0]  tilt_rate_gain;
        logic signed [GAIN_W-1:0]  tilt_int_gain;
        logic signed [ANGLE_W-1:0] balance_offset;
        logic        [DUTY_W-1:0]  duty_cap;
    } gains_t;

    // control of the front stage: load the operand register, advance the integrators
    typedef struct packed {
        logic load;
        logic step;
    } front_ctrl_t;

    localparam logic signed [GAIN_W-1:0]  RST_SPEED_GAIN     = 24'sd3840;
    localparam logic signed [GAIN_W-1:0]  RST_SPEED_INT_GAIN = 24'sd2099;
    localparam logic signed [GAIN_W-1:0]  RST_TILT_GAIN      = -24'sd35840;
    localparam logic signed [GAIN_W-1:0]  RST_TILT_RATE_GAIN = 24'sd26;
    localparam logic signed [GAIN_W-1:0]  RST_TILT_INT_GAIN  = -24'sd512;
    localparam logic signed [ANGLE_W-1:0] RST_BALANCE_OFFSET = 17'sd0;
    localparam logic        [DUTY_W-1:0]  RST_DUTY_CAP       = 16'd1000;

endpackage

`default_nettype wire

// File: design/bvm_front.sv
// bvm_front: error terms, integrator updates and gain scheduling
// holds both integrator registers and the operand register; uses bvm_pkg
`default_nettype none

module bvm_front #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire bvm_pkg::front_ctrl_t                  ctrl,
    input  wire bvm_pkg::gains_t                       gains,
    input  wire logic signed [bvm_pkg::ANGLE_W-1:0]    pitch_angle,
    input  wire logic signed [bvm_pkg::RATE_W-1:0]     pitch_rate,
    input  wire logic        [bvm_pkg::COUNT_W-1:0]    wheel_a_count,
    input  wire logic        [bvm_pkg::COUNT_W-1:0]    wheel_b_count,
    input  wire logic signed [bvm_pkg::TARGET_W-1:0]   speed_target,
    output logic signed [17-1:0]                       err_v_reg,
    output logic signed [bvm_pkg::SPEED_INT_W-1:0]     speed_int_reg,
    output logic signed [((FRAC_BITS+7) > 24 ? (FRAC_BITS+7) : 24):0] ki_v_reg,
    output logic signed [18-1:0]                       bias_reg,
    output logic signed [bvm_pkg::RATE_W-1:0]          rate_reg,
    output logic signed [((FRAC_BITS+12) > 19 ? (FRAC_BITS+12) : 19)-1:0] tilt_int_reg
);

    localparam int KI_W = ((FRAC_BITS + 7) > 24 ? (FRAC_BITS + 7) : 24) + 1;
    localparam int TI_W = (FRAC_BITS + 12) > 19 ? (FRAC_BITS + 12) : 19;
    localparam int LIM_T = 1000 * (1 << FRAC_BITS);
    localparam logic signed [TI_W-1:0] TI_MAX = TI_W'(LIM_T);
    localparam logic signed [TI_W-1:0] TI_MIN = -TI_W'(LIM_T);
    localparam logic signed [17:0] SI_MAX = 18'(bvm_pkg::SPEED_INT_LIM);
    localparam logic signed [17:0] SI_MIN = -18'(bvm_pkg::SPEED_INT_LIM);

    logic signed [bvm_pkg::SPEED_INT_W-1:0] speed_integral_reg;
    logic signed [bvm_pkg::SPEED_INT_W-1:0] speed_integral_next;
    logic signed [TI_W-1:0]                 tilt_integral_reg;
    logic signed [TI_W-1:0]                 tilt_integral_next;

    logic signed [16:0] enc_sum;
    logic signed [16:0] enc_adj;
    logic signed [15:0] enc_mean;
    logic signed [16:0] err_v;
    logic signed [17:0] si_sum;
    logic        [10:0] t_mag;
    logic        [22:0] q_prod;
    logic        [6:0]  q_mag;
    logic signed [7:0]  q_s;
    logic signed [KI_W-1:0] ki_v;
    logic signed [17:0] bias;
    logic signed [TI_W-1:0] ti_held;

    // velocity error: counts read as signed deltas, mean rounds toward zero
    always_comb
    begin
        enc_sum  = 17'($signed(wheel_a_count)) + 17'($signed(wheel_b_count));
        enc_adj  = enc_sum + $signed({16'd0, enc_sum[16]});
        enc_mean = 16'(enc_adj >>> 1);
        err_v    = 17'(speed_target) - 17'(enc_mean);
        si_sum   = 18'(speed_integral_reg) + 18'(err_v);
        if (si_sum > SI_MAX)
            speed_integral_next = bvm_pkg::SPEED_INT_W'(SI_MAX);
        else if (si_sum < SI_MIN)
            speed_integral_next = bvm_pkg::SPEED_INT_W'(SI_MIN);
        else
            speed_integral_next = bvm_pkg::SPEED_INT_W'(si_sum);
    end

    // integral gain falls by target/20 whole units, quotient toward zero
    always_comb
    begin
        t_mag  = speed_target[10] ? 11'(-speed_target) : 11'(speed_target);
        q_prod = 23'(t_mag) * 23'(bvm_pkg::RECIP20);
        q_mag  = q_prod[bvm_pkg::RECIP20_SHIFT +: 7];
        q_s    = speed_target[10] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
        ki_v   = KI_W'(gains.speed_int_gain_base) - (KI_W'(q_s) <<< FRAC_BITS);
    end

    // angle integral is limited before the new error goes in
    always_comb
    begin
        bias = 18'(gains.balance_offset) - 18'(pitch_angle);
        if (tilt_integral_reg > TI_MAX)
            ti_held = TI_MAX;
        else if (tilt_integral_reg < TI_MIN)
            ti_held = TI_MIN;
        else
            ti_held = tilt_integral_reg;
        tilt_integral_next = ti_held + TI_W'(bias);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_integral_reg <= '0;
            tilt_integral_reg  <= '0;
        end
        else if (ctrl.step)
        begin
            speed_integral_reg <= speed_integral_next;
            tilt_integral_reg  <= tilt_integral_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            err_v_reg     <= err_v;
            speed_int_reg <= speed_integral_next;
            ki_v_reg      <= ki_v;
            bias_reg      <= bias;
            rate_reg      <= pitch_rate;
            tilt_int_reg  <= tilt_integral_next;
        end
    end

endmodule

`default_nettype wire

// File: design/bvm_mult.sv
// bvm_mult: the five gain products, one multiplier each, registered
// uses bvm_pkg for gain and field widths
`default_nettype none

module bvm_mult #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                                  clk,
    input  wire logic                                  load,
    input  wire bvm_pkg::gains_t                       gains,
    input  wire logic signed [17-1:0]                  err_v,
    input  wire logic signed [bvm_pkg::SPEED_INT_W-1:0] speed_int,
    input  wire logic signed [((FRAC_BITS+7) > 24 ? (FRAC_BITS+7) : 24):0] ki_v,
    input  wire logic signed [18-1:0]                  bias,
    input  wire logic signed [bvm_pkg::RATE_W-1:0]     rate,
    input  wire logic signed [((FRAC_BITS+12) > 19 ? (FRAC_BITS+12) : 19)-1:0] tilt_int,
    output logic signed [17+24-1:0]                    p_speed_reg,
    output logic signed [bvm_pkg::SPEED_INT_W+((FRAC_BITS+7) > 24 ? (FRAC_BITS+7) : 24):0]
                                                       p_speed_int_reg,
    output logic signed [18+24-1:0]                    p_tilt_reg,
    output logic signed [16+24-1:0]                    p_rate_reg,
    output logic signed [((FRAC_BITS+12) > 19 ? (FRAC_BITS+12) : 19)+24-1:0] p_tilt_int_reg
);

    localparam int KI_W = ((FRAC_BITS + 7) > 24 ? (FRAC_BITS + 7) : 24) + 1;
    localparam int TI_W = (FRAC_BITS + 12) > 19 ? (FRAC_BITS + 12) : 19;
    localparam int P1_W = 17 + bvm_pkg::GAIN_W;
    localparam int P2_W = bvm_pkg::SPEED_INT_W + KI_W;
    localparam int P3_W = 18 + bvm_pkg::GAIN_W;
    localparam int P4_W = bvm_pkg::RATE_W + bvm_pkg::GAIN_W;
    localparam int P5_W = TI_W + bvm_pkg::GAIN_W;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p_speed_reg     <= P1_W'(err_v) * P1_W'(gains.speed_gain);
            p_speed_int_reg <= P2_W'(speed_int) * P2_W'(ki_v);
            p_tilt_reg      <= P3_W'(bias) * P3_W'(gains.tilt_gain);
            p_rate_reg      <= P4_W'(rate) * P4_W'(gains.tilt_rate_gain);
            p_tilt_int_reg  <= P5_W'(tilt_int) * P5_W'(gains.tilt_int_gain);
        end
    end

endmodule

`default_nettype wire

// File: design/bvm_terms.sv
// bvm_terms: scales the products back, sums each term and saturates to 24 bits
// uses bvm_pkg for the term width
`default_nettype none

module bvm_terms #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                                  clk,
    input  wire logic                                  load,
    input  wire logic signed [17+24-1:0]               p_speed,
    input  wire logic signed [bvm_pkg::SPEED_INT_W+((FRAC_BITS+7) > 24 ? (FRAC_BITS+7) : 24):0]
                                                       p_speed_int,
    input  wire logic signed [18+24-1:0]               p_tilt,
    input  wire logic signed [16+24-1:0]               p_rate,
    input  wire logic signed [((FRAC_BITS+12) > 19 ? (FRAC_BITS+12) : 19)+24-1:0] p_tilt_int,
    output logic signed [bvm_pkg::TERM_W-1:0]          tilt_term_reg,
    output logic signed [bvm_pkg::TERM_W-1:0]          speed_term_reg
);

    localparam int KI_W = ((FRAC_BITS + 7) > 24 ? (FRAC_BITS + 7) : 24) + 1;
    localparam int TI_W = (FRAC_BITS + 12) > 19 ? (FRAC_BITS + 12) : 19;
    localparam int P2_W = bvm_pkg::SPEED_INT_W + KI_W;
    localparam int P5_W = TI_W + bvm_pkg::GAIN_W;
    localparam int PMAX_A = P2_W > P5_W ? P2_W : P5_W;
    localparam int EXT_W = (PMAX_A > 42 ? PMAX_A : 42) + 1;
    localparam int SUM_W = EXT_W + 2;
    localparam logic signed [SUM_W-1:0] T_MAX = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] T_MIN = SUM_W'(-8388608);

    // divide by 2^k rounding toward zero
    function automatic logic signed [EXT_W-1:0] trunc_shift(
        input logic signed [EXT_W-1:0] p,
        input int unsigned             k
    );
        logic signed [EXT_W-1:0] mag;
        mag = (p < 0) ? ((-p) >>> k) : (p >>> k);
        return (p < 0) ? -mag : mag;
    endfunction

    function automatic logic signed [bvm_pkg::TERM_W-1:0] sat_term(
        input logic signed [SUM_W-1:0] s
    );
        logic signed [SUM_W-1:0] c;
        if (s > T_MAX)
            c = T_MAX;
        else if (s < T_MIN)
            c = T_MIN;
        else
            c = s;
        return bvm_pkg::TERM_W'(c);
    endfunction

    logic signed [SUM_W-1:0] speed_sum;
    logic signed [SUM_W-1:0] tilt_sum;

    always_comb
    begin
        speed_sum = SUM_W'(trunc_shift(EXT_W'(p_speed), FRAC_BITS))
                  + SUM_W'(trunc_shift(EXT_W'(p_speed_int), FRAC_BITS));
        tilt_sum  = SUM_W'(trunc_shift(EXT_W'(p_tilt), 2 * FRAC_BITS))
                  + SUM_W'(trunc_shift(EXT_W'(p_rate), FRAC_BITS))
                  + SUM_W'(trunc_shift(EXT_W'(p_tilt_int), 2 * FRAC_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            speed_term_reg <= sat_term(speed_sum);
            tilt_term_reg  <= sat_term(tilt_sum);
        end
    end

endmodule

`default_nettype wire

// File: design/bvm_drive.sv
// bvm_drive: averages the two terms and forms direction and duty per wheel
// result register of the pipeline; uses bvm_pkg for widths
`default_nettype none

module bvm_drive (
    input  wire logic                                  clk,
    input  wire logic                                  load,
    input  wire logic        [bvm_pkg::DUTY_W-1:0]     duty_cap,
    input  wire logic signed [bvm_pkg::TERM_W-1:0]     tilt_term,
    input  wire logic signed [bvm_pkg::TERM_W-1:0]     speed_term,
    output logic                                       motor_a_reverse_reg,
    output logic        [bvm_pkg::DUTY_W-1:0]          motor_a_duty_reg,
    output logic                                       motor_b_reverse_reg,
    output logic        [bvm_pkg::DUTY_W-1:0]          motor_b_duty_reg,
    output logic signed [bvm_pkg::TERM_W-1:0]          tilt_term_reg,
    output logic signed [bvm_pkg::TERM_W-1:0]          speed_term_reg
);

    logic signed [bvm_pkg::TERM_W:0]   mix;
    logic signed [bvm_pkg::TERM_W:0]   mix_adj;
    logic signed [bvm_pkg::TERM_W-1:0] avg;
    logic        [bvm_pkg::TERM_W-1:0] mag;
    logic        [bvm_pkg::DUTY_W-1:0] duty;

    // mean rounds toward zero; wheel b takes the negation so shares the magnitude
    always_comb
    begin
        mix     = (bvm_pkg::TERM_W+1)'(tilt_term) + (bvm_pkg::TERM_W+1)'(speed_term);
        mix_adj = mix + $signed({{bvm_pkg::TERM_W{1'b0}}, mix[bvm_pkg::TERM_W]});
        avg     = bvm_pkg::TERM_W'(mix_adj >>> 1);
        mag     = avg[bvm_pkg::TERM_W-1] ? bvm_pkg::TERM_W'(-avg) : bvm_pkg::TERM_W'(avg);
        duty    = (mag > bvm_pkg::TERM_W'(duty_cap)) ? duty_cap : mag[bvm_pkg::DUTY_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            motor_a_reverse_reg <= avg[bvm_pkg::TERM_W-1];
            motor_a_duty_reg    <= duty;
            motor_b_reverse_reg <= !avg[bvm_pkg::TERM_W-1] && (avg != '0);
            motor_b_duty_reg    <= duty;
            tilt_term_reg       <= tilt_term;
            speed_term_reg      <= speed_term;
        end
    end

endmodule

`default_nettype wire

// File: design/balance_velocity_motor_loop.sv
// balance_velocity_motor_loop: top level of the two-wheel balance and velocity loop
// input register, configuration registers and pipeline control; uses bvm_pkg,
// bvm_front, bvm_mult, bvm_terms and bvm_drive
//
//  channel  direction  handshake                  word contents
//  s_*      in         s_tvalid / s_tready        one sensor sample
//  m_*      out        m_tvalid / m_tready        motor commands and both terms
//  cfg_*    in         cfg_valid / cfg_ready      register index and write data
//
// one word accepted per cycle unless back-pressure stalls the input; each sample passes
// through the input, operand, product, term and result registers in turn
// the integrators close their loop within the front stage, which sets the rate
// reset clears both integrators, all stage valid flags and loads the register defaults
// each stage holds while the one after it is full and stalled, so bubbles close up
// configuration writes are always taken (cfg_ready stays high)
`default_nettype none

module balance_velocity_motor_loop #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // sample: pitch_angle[16:0], pitch_rate[32:17], wheel_a_count[48:33],
    // wheel_b_count[64:49], speed_target[75:65], zero pad above
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,
    // result: motor_a_reverse[0], motor_a_duty[16:1], motor_b_reverse[17],
    // motor_b_duty[33:18], tilt_term[57:34], speed_term[81:58], zero pad above
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,
    // configuration write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [bvm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bvm_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int KI_W = ((FRAC_BITS + 7) > 24 ? (FRAC_BITS + 7) : 24) + 1;
    localparam int TI_W = (FRAC_BITS + 12) > 19 ? (FRAC_BITS + 12) : 19;

    bvm_pkg::gains_t gains_reg;

    // stage valid flags: a input, b operands, c products, d terms, e result
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg;
    logic ready_a, ready_b, ready_c, ready_d, ready_e;

    logic signed [bvm_pkg::ANGLE_W-1:0]  pitch_angle_reg;
    logic signed [bvm_pkg::RATE_W-1:0]   pitch_rate_reg;
    logic        [bvm_pkg::COUNT_W-1:0]  wheel_a_count_reg;
    logic        [bvm_pkg::COUNT_W-1:0]  wheel_b_count_reg;
    logic signed [bvm_pkg::TARGET_W-1:0] speed_target_reg;

    bvm_pkg::front_ctrl_t front_ctrl;

    logic signed [16:0]                      err_v;
    logic signed [bvm_pkg::SPEED_INT_W-1:0]  speed_int;
    logic signed [KI_W-1:0]                  ki_v;
    logic signed [17:0]                      bias;
    logic signed [bvm_pkg::RATE_W-1:0]       rate;
    logic signed [TI_W-1:0]                  tilt_int;

    logic signed [17+24-1:0]                        p_speed;
    logic signed [bvm_pkg::SPEED_INT_W+KI_W-1:0]    p_speed_int;
    logic signed [18+24-1:0]                        p_tilt;
    logic signed [16+24-1:0]                        p_rate;
    logic signed [TI_W+24-1:0]                      p_tilt_int;

    logic signed [bvm_pkg::TERM_W-1:0] tilt_term_d;
    logic signed [bvm_pkg::TERM_W-1:0] speed_term_d;

    logic                              motor_a_reverse;
    logic        [bvm_pkg::DUTY_W-1:0] motor_a_duty;
    logic                              motor_b_reverse;
    logic        [bvm_pkg::DUTY_W-1:0] motor_b_duty;
    logic signed [bvm_pkg::TERM_W-1:0] tilt_term;
    logic signed [bvm_pkg::TERM_W-1:0] speed_term;

    // ready ripples back from the result register; an empty stage always takes a word
    always_comb
    begin
        ready_e = !e_valid_reg || m_tready;
        ready_d = !d_valid_reg || ready_e;
        ready_c = !c_valid_reg || ready_d;
        ready_b = !b_valid_reg || ready_c;
        ready_a = !a_valid_reg || ready_b;
        front_ctrl.load = ready_b;
        front_ctrl.step = a_valid_reg && ready_b;
    end

    assign s_tready  = ready_a;
    assign m_tvalid  = e_valid_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
                a_valid_reg <= s_tvalid;
            if (ready_b)
                b_valid_reg <= a_valid_reg;
            if (ready_c)
                c_valid_reg <= b_valid_reg;
            if (ready_d)
                d_valid_reg <= c_valid_reg;
            if (ready_e)
                e_valid_reg <= d_valid_reg;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (ready_a)
        begin
            pitch_angle_reg   <= $signed(s_tdata[16:0]);
            pitch_rate_reg    <= $signed(s_tdata[32:17]);
            wheel_a_count_reg <= s_tdata[48:33];
            wheel_b_count_reg <= s_tdata[64:49];
            speed_target_reg  <= $signed(s_tdata[75:65]);
        end
    end

    // configuration registers; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.speed_gain          <= bvm_pkg::RST_SPEED_GAIN;
            gains_reg.speed_int_gain_base <= bvm_pkg::RST_SPEED_INT_GAIN;
            gains_reg.tilt_gain           <= bvm_pkg::RST_TILT_GAIN;
            gains_reg.tilt_rate_gain      <= bvm_pkg::RST_TILT_RATE_GAIN;
            gains_reg.tilt_int_gain       <= bvm_pkg::RST_TILT_INT_GAIN;
            gains_reg.balance_offset      <= bvm_pkg::RST_BALANCE_OFFSET;
            gains_reg.duty_cap            <= bvm_pkg::RST_DUTY_CAP;
        end
        else if (cfg_valid)
        begin
            unique case (bvm_pkg::reg_idx_t'(cfg_index))
                bvm_pkg::REG_SPEED_GAIN:     gains_reg.speed_gain          <= $signed(cfg_data);
                bvm_pkg::REG_SPEED_INT_GAIN: gains_reg.speed_int_gain_base <= $signed(cfg_data);
                bvm_pkg::REG_TILT_GAIN:      gains_reg.tilt_gain           <= $signed(cfg_data);
                bvm_pkg::REG_TILT_RATE_GAIN: gains_reg.tilt_rate_gain      <= $signed(cfg_data);
                bvm_pkg::REG_TILT_INT_GAIN:  gains_reg.tilt_int_gain       <= $signed(cfg_data);
                bvm_pkg::REG_BALANCE_OFFSET:
                    gains_reg.balance_offset <= $signed(cfg_data[bvm_pkg::ANGLE_W-1:0]);
                bvm_pkg::REG_DUTY_CAP:
                    gains_reg.duty_cap <= cfg_data[bvm_pkg::DUTY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    bvm_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (front_ctrl),
        .gains         (gains_reg),
        .pitch_angle   (pitch_angle_reg),
        .pitch_rate    (pitch_rate_reg),
        .wheel_a_count (wheel_a_count_reg),
        .wheel_b_count (wheel_b_count_reg),
        .speed_target  (speed_target_reg),
        .err_v_reg     (err_v),
        .speed_int_reg (speed_int),
        .ki_v_reg      (ki_v),
        .bias_reg      (bias),
        .rate_reg      (rate),
        .tilt_int_reg  (tilt_int)
    );

    bvm_mult #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mult (
        .clk             (clk),
        .load            (ready_c),
        .gains           (gains_reg),
        .err_v           (err_v),
        .speed_int       (speed_int),
        .ki_v            (ki_v),
        .bias            (bias),
        .rate            (rate),
        .tilt_int        (tilt_int),
        .p_speed_reg     (p_speed),
        .p_speed_int_reg (p_speed_int),
        .p_tilt_reg      (p_tilt),
        .p_rate_reg      (p_rate),
        .p_tilt_int_reg  (p_tilt_int)
    );

    bvm_terms #(
        .FRAC_BITS (FRAC_BITS)
    ) u_terms (
        .clk            (clk),
        .load           (ready_d),
        .p_speed        (p_speed),
        .p_speed_int    (p_speed_int),
        .p_tilt         (p_tilt),
        .p_rate         (p_rate),
        .p_tilt_int     (p_tilt_int),
        .tilt_term_reg  (tilt_term_d),
        .speed_term_reg (speed_term_d)
    );

    bvm_drive u_drive (
        .clk                 (clk),
        .load                (ready_e),
        .duty_cap            (gains_reg.duty_cap),
        .tilt_term           (tilt_term_d),
        .speed_term          (speed_term_d),
        .motor_a_reverse_reg (motor_a_reverse),
        .motor_a_duty_reg    (motor_a_duty),
        .motor_b_reverse_reg (motor_b_reverse),
        .motor_b_duty_reg    (motor_b_duty),
        .tilt_term_reg       (tilt_term),
        .speed_term_reg      (speed_term)
    );

    assign m_tdata = {6'd0, speed_term, tilt_term, motor_b_duty, motor_b_reverse,
                      motor_a_duty, motor_a_reverse};

endmodule

`default_nettype wire

// File: bench/balance_velocity_motor_loop_test.sv
// balance_velocity_motor_loop_test: self-checking bench for the balance and velocity motor loop
// holds the drive scoreboard and predictor, the sample and settings drivers and the result monitor
// depends on bvm_pkg and balance_velocity_motor_loop
`default_nettype none

module balance_velocity_motor_loop_test;

    localparam int     Q_BITS    = 8;
    localparam int     LATENCY   = 4;
    localparam longint TERM_MAX  = 64'sd8388607;
    localparam longint TERM_MIN  = -64'sd8388608;
    // register index with no register behind it, writes there are dropped
    localparam logic [bvm_pkg::CFG_IDX_W-1:0] UNKNOWN_REG = 3'd7;

    // sample word, first field in the lowest bits
    typedef struct packed {
        logic signed [bvm_pkg::TARGET_W-1:0] speed_target;
        logic        [bvm_pkg::COUNT_W-1:0]  wheel_b_count;
        logic        [bvm_pkg::COUNT_W-1:0]  wheel_a_count;
        logic signed [bvm_pkg::RATE_W-1:0]   pitch_rate;
        logic signed [bvm_pkg::ANGLE_W-1:0]  pitch_angle;
    } sample_t;

    // result word, first field in the lowest bits
    typedef struct packed {
        logic signed [bvm_pkg::TERM_W-1:0] speed_term;
        logic signed [bvm_pkg::TERM_W-1:0] tilt_term;
        logic        [bvm_pkg::DUTY_W-1:0] b_duty;
        logic                              b_rev;
        logic        [bvm_pkg::DUTY_W-1:0] a_duty;
        logic                              a_rev;
    } motor_cmd_t;

    typedef enum int {PH_DEFAULT, PH_MAX, PH_MIN, PH_RANDOM, PH_MODERATE, PH_NOMINAL} phase_t;
    typedef enum int {RX_ALWAYS, RX_COIN, RX_EVERY_THIRD, RX_LONG_STALL} rx_mode_t;

    // ------------------------------------------------------------------
    // scoreboard: own copy of the gains and both integrators, predicts the
    // motor command of every accepted sample and checks results in order
    // ------------------------------------------------------------------
    class drive_scoreboard;
        longint     speed_gain, speed_int_base, tilt_gain, tilt_rate_gain, tilt_int_gain;
        longint     offset, duty_limit;
        longint     speed_acc, tilt_acc;
        motor_cmd_t drive_queue[$];
        int         mismatches;

        function new();
            speed_gain     = bvm_pkg::RST_SPEED_GAIN;
            speed_int_base = bvm_pkg::RST_SPEED_INT_GAIN;
            tilt_gain      = bvm_pkg::RST_TILT_GAIN;
            tilt_rate_gain = bvm_pkg::RST_TILT_RATE_GAIN;
            tilt_int_gain  = bvm_pkg::RST_TILT_INT_GAIN;
            offset         = bvm_pkg::RST_BALANCE_OFFSET;
            duty_limit     = bvm_pkg::RST_DUTY_CAP;
            speed_acc      = 0;
            tilt_acc       = 0;
            mismatches     = 0;
        endfunction

        function void set_register(logic [bvm_pkg::CFG_IDX_W-1:0] idx,
                                   logic [bvm_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                bvm_pkg::REG_SPEED_GAIN:     speed_gain     = $signed(data);
                bvm_pkg::REG_SPEED_INT_GAIN: speed_int_base = $signed(data);
                bvm_pkg::REG_TILT_GAIN:      tilt_gain      = $signed(data);
                bvm_pkg::REG_TILT_RATE_GAIN: tilt_rate_gain = $signed(data);
                bvm_pkg::REG_TILT_INT_GAIN:  tilt_int_gain  = $signed(data);
                bvm_pkg::REG_BALANCE_OFFSET: offset = $signed(data[bvm_pkg::ANGLE_W-1:0]);
                bvm_pkg::REG_DUTY_CAP:       duty_limit = data[bvm_pkg::DUTY_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void dir_and_duty(longint v, output logic rev,
                                   output logic [bvm_pkg::DUTY_W-1:0] duty);
            longint mag;
            rev = (v < 0);
            mag = (v < 0) ? -v : v;
            if (mag > duty_limit)
                mag = duty_limit;
            duty = mag[bvm_pkg::DUTY_W-1:0];
        endfunction

        // one control step: velocity PI, balance PID, average, split to wheels
        function void note_sample(sample_t smp);
            longint     one, one2, lim_t, angle, rate, enc_a, enc_b, target;
            longint     vel_err, int_gain, vel_out, bias, tilt_out, avg;
            motor_cmd_t cmd;
            one    = longint'(1) << Q_BITS;
            one2   = one * one;
            lim_t  = 1000 * one;
            angle  = $signed(smp.pitch_angle);
            rate   = $signed(smp.pitch_rate);
            enc_a  = $signed(smp.wheel_a_count);
            enc_b  = $signed(smp.wheel_b_count);
            target = $signed(smp.speed_target);

            // speed integral clamps after the error goes in
            vel_err   = target - (enc_a + enc_b) / 2;
            speed_acc = clip(speed_acc + vel_err, -bvm_pkg::SPEED_INT_LIM,
                             bvm_pkg::SPEED_INT_LIM);
            int_gain  = speed_int_base - (target / 20) * one;
            vel_out   = clip((vel_err * speed_gain) / one + (speed_acc * int_gain) / one,
                             TERM_MIN, TERM_MAX);

            // angle integral clamps before the error goes in
            tilt_acc = clip(tilt_acc, -lim_t, lim_t);
            bias     = offset - angle;
            tilt_acc = tilt_acc + bias;
            tilt_out = clip((bias * tilt_gain) / one2 + (rate * tilt_rate_gain) / one
                            + (tilt_acc * tilt_int_gain) / one2, TERM_MIN, TERM_MAX);

            avg = (tilt_out + vel_out) / 2;
            dir_and_duty(avg, cmd.a_rev, cmd.a_duty);
            dir_and_duty(-avg, cmd.b_rev, cmd.b_duty);
            cmd.tilt_term  = tilt_out[bvm_pkg::TERM_W-1:0];
            cmd.speed_term = vel_out[bvm_pkg::TERM_W-1:0];
            drive_queue.push_back(cmd);
        endfunction

        function void compare(string name, longint want, longint got);
            if (want != got)
            begin
                $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_word(logic [87:0] word);
            motor_cmd_t got, want;
            got = word[$bits(motor_cmd_t)-1:0];
            if (drive_queue.size() == 0)
            begin
                $display("%0t unexpected result word: expected none, actual %h", $time, word);
                mismatches++;
                return;
            end
            want = drive_queue.pop_front();
            compare("motor_a_reverse", want.a_rev, got.a_rev);
            compare("motor_a_duty", want.a_duty, got.a_duty);
            compare("motor_b_reverse", want.b_rev, got.b_rev);
            compare("motor_b_duty", want.b_duty, got.b_duty);
            compare("tilt_term", $signed(want.tilt_term), $signed(got.tilt_term));
            compare("speed_term", $signed(want.speed_term), $signed(got.speed_term));
        endfunction

        function int pending();
            return drive_queue.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------
    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [79:0]                    s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [87:0]                    m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [bvm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bvm_pkg::CFG_DATA_W-1:0] cfg_data;

    balance_velocity_motor_loop #(
        .FRAC_BITS (Q_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    drive_scoreboard                sb;
    logic [bvm_pkg::CFG_DATA_W-1:0] settings [7];

    // sender burst state
    int burst_left = 0;

    // state of the current random run: a steady target, lean and wheel speed
    int run_left   = 0;
    int run_target = 0;
    int run_angle  = 0;
    int run_speed  = 0;

    // receiver stall pattern state
    rx_mode_t rx_mode = RX_ALWAYS;
    int       rx_left = 0;
    int       rx_tick = 0;
    int       rx_hold = 0;

    // ------------------------------------------------------------------
    // result monitor: every word taken at a rising edge goes to the scoreboard
    // ------------------------------------------------------------------
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata);

    // ------------------------------------------------------------------
    // receiver stalls, each pattern held for a run of random length; one mode
    // never stalls so long stretches without back-pressure occur too
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(RX_ALWAYS, RX_LONG_STALL));
            rx_left = $urandom_range(20, 150);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_ALWAYS:      m_tready <= 1'b1;
            RX_COIN:        m_tready <= $urandom_range(0, 1);
            RX_EVERY_THIRD: m_tready <= (rx_tick % 3 == 0);
            default:
            begin
                // long stall, then a single ready cycle
                if (rx_hold == 0)
                begin
                    m_tready <= 1'b1;
                    rx_hold = $urandom_range(1, 10);
                end
                else
                begin
                    m_tready <= 1'b0;
                    rx_hold--;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sample construction
    // ------------------------------------------------------------------
    function automatic sample_t mk_sample(int angle, int rate, int cnt_a, int cnt_b, int target);
        sample_t smp;
        smp.pitch_angle   = angle[bvm_pkg::ANGLE_W-1:0];
        smp.pitch_rate    = rate[bvm_pkg::RATE_W-1:0];
        smp.wheel_a_count = cnt_a[bvm_pkg::COUNT_W-1:0];
        smp.wheel_b_count = cnt_b[bvm_pkg::COUNT_W-1:0];
        smp.speed_target  = target[bvm_pkg::TARGET_W-1:0];
        return smp;
    endfunction

    // mostly steady runs so both integrators wind up to their clamps,
    // with full-width noise words mixed in to break the runs
    function automatic sample_t next_random_sample();
        int jit;
        if (run_left == 0)
        begin
            run_left   = $urandom_range(8, 60);
            run_target = $urandom_range(0, 2000) - 1000;
            run_angle  = $urandom_range(0, 90000) - 45000;
            run_speed  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60000) - 30000
                                                     : $urandom_range(0, 3000) - 1500;
        end
        run_left--;
        if ($urandom_range(0, 99) < 15)
            return mk_sample($urandom, $urandom, $urandom, $urandom, $urandom);
        jit = $urandom_range(0, 20) - 10;
        return mk_sample(run_angle + $urandom_range(0, 2000) - 1000,
                         $urandom_range(0, 4000) - 2000,
                         run_speed + jit, run_speed - jit + $urandom_range(0, 4) - 2,
                         run_target);
    endfunction

    // ------------------------------------------------------------------
    // drivers: inputs move at the falling edge, handshakes are seen at the rising edge
    // ------------------------------------------------------------------
    task automatic send_sample(input sample_t smp);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, smp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_sample(smp);
    endtask

    // bursts of random length, random gaps between them, some gaps empty
    task automatic stream_sample(input sample_t smp);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1)
                    @(negedge clk);
            end
        end
        burst_left--;
        send_sample(smp);
    endtask

    // stop sending and wait until every predicted word has come back
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // drained and past the pipeline depth, safe to touch the registers
    task automatic settle();
        drain();
        repeat (LATENCY + 4)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [bvm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bvm_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            // sender holds off mid-run until the block has emptied
            if (n == count / 2)
                drain();
            stream_sample(next_random_sample());
        end
    endtask

    // register values of each phase, extremes included
    task automatic pick_settings(input phase_t ph);
        for (int i = bvm_pkg::REG_SPEED_GAIN; i <= bvm_pkg::REG_DUTY_CAP; i++)
        begin
            case (ph)
                PH_MAX:      settings[i] = 24'h7FFFFF;
                PH_MIN:      settings[i] = 24'h800000;
                PH_RANDOM:   settings[i] = $urandom;
                PH_MODERATE: settings[i] = $urandom_range(0, 131072) - 65536;
                default:     settings[i] = 24'h000000;
            endcase
        end
        case (ph)
            PH_MAX:
            begin
                settings[bvm_pkg::REG_BALANCE_OFFSET] = 24'h00FFFF;
                settings[bvm_pkg::REG_DUTY_CAP]       = 24'h00FFFF;
            end
            PH_MIN:
            begin
                settings[bvm_pkg::REG_BALANCE_OFFSET] = 24'h010000;
                settings[bvm_pkg::REG_DUTY_CAP]       = 24'h000000;
            end
            PH_MODERATE:
            begin
                settings[bvm_pkg::REG_BALANCE_OFFSET] = $urandom_range(0, 92160) - 46080;
                settings[bvm_pkg::REG_DUTY_CAP]       = $urandom_range(0, 65535);
            end
            PH_NOMINAL:
            begin
                // defaults again, with the duty limit wide open
                settings[bvm_pkg::REG_SPEED_GAIN]     = bvm_pkg::RST_SPEED_GAIN;
                settings[bvm_pkg::REG_SPEED_INT_GAIN] = bvm_pkg::RST_SPEED_INT_GAIN;
                settings[bvm_pkg::REG_TILT_GAIN]      = bvm_pkg::RST_TILT_GAIN;
                settings[bvm_pkg::REG_TILT_RATE_GAIN] = bvm_pkg::RST_TILT_RATE_GAIN;
                settings[bvm_pkg::REG_TILT_INT_GAIN]  = bvm_pkg::RST_TILT_INT_GAIN;
                settings[bvm_pkg::REG_BALANCE_OFFSET] = bvm_pkg::RST_BALANCE_OFFSET;
                settings[bvm_pkg::REG_DUTY_CAP]       = 24'h00FFFF;
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words at the reset settings
        // all zero: zero drive, both wheels forward with no duty
        stream_sample(mk_sample(0, 0, 0, 0, 0));
        // angle and rate extremes, in range and at full width
        stream_sample(mk_sample(46080, 0, 0, 0, 0));
        stream_sample(mk_sample(-46080, 0, 0, 0, 0));
        stream_sample(mk_sample(65535, 32767, 16'h7FFF, 16'h7FFF, 1023));
        stream_sample(mk_sample(-65536, -32768, 16'h8000, 16'h8000, -1024));
        // encoder counts as signed deltas, mean rounding toward zero
        stream_sample(mk_sample(0, 0, 16'hFFFF, 16'h0000, 0));
        stream_sample(mk_sample(0, 0, 16'hFFFF, 16'hFFFE, 0));
        stream_sample(mk_sample(0, 0, 16'h0001, 16'hFFFF, 19));
        // target over 20 rounding toward zero on both signs
        stream_sample(mk_sample(0, 0, 0, 0, -19));
        stream_sample(mk_sample(0, 0, 0, 0, 20));
        stream_sample(mk_sample(0, 0, 0, 0, -21));
        // wind both integrators into their clamps, negative drive saturating
        repeat (10)
            stream_sample(mk_sample(-46080, 0, 0, 0, 1000));
        // and back the other way
        repeat (4)
            stream_sample(mk_sample(46080, 0, 0, 0, -1000));

        run_random(230);

        // further phases, registers only written once the block is empty
        for (int p = PH_MAX; p <= PH_NOMINAL; p++)
        begin
            settle();
            pick_settings(phase_t'(p));
            for (int i = bvm_pkg::REG_SPEED_GAIN; i <= bvm_pkg::REG_DUTY_CAP; i++)
                cfg_write(bvm_pkg::reg_idx_t'(i), settings[i]);
            if (p == PH_RANDOM)
                cfg_write(UNKNOWN_REG, $urandom);
            run_random(230);
        end

        settle();
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
